// ----- rtl/wall_follow_steering_defines.svh -----
// ----------------------------------------------------------------------------
// Wall-follow steering assertion macros
// Shared property macros for the checker of the wall-follow steering block.
// ----------------------------------------------------------------------------
`ifndef WALL_FOLLOW_STEERING_DEFINES_SVH
`define WALL_FOLLOW_STEERING_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WFS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall-follow steering package
// Types, widths and register codes shared by the modules of the block.
// ----------------------------------------------------------------------------
package wfs_pkg;

    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int CORDIC_W  = 38;
    localparam int DIV_STEPS = 17;
    localparam int PROD_W    = 16 + CORDIC_W;

    typedef enum logic [2:0] {
        REG_SIDE_INDEX,
        REG_ANGLED_INDEX,
        REG_RANGE_LIMIT,
        REG_STEER_GAIN,
        REG_TARGET_DIST,
        REG_FORWARD_SPEED,
        REG_BEAM_COS,
        REG_BEAM_SIN
    } reg_index_t;

    typedef struct packed {
        logic [9:0]         side_index;
        logic [9:0]         angled_index;
        logic [15:0]        range_limit;
        logic signed [15:0] steer_gain;
        logic [15:0]        target_distance;
        logic [15:0]        forward_speed;
        logic [15:0]        beam_cos;
        logic [15:0]        beam_sin;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic accept_last;
        logic prep;
        logic cordic_step;
        logic cordic_switch;
        logic product;
        logic div_load;
        logic div_step;
        logic rate;
        logic write;
    } cmd_t;

    typedef struct packed {
        logic d_zero;
        logic cordic_last;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/wfs_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall-follow steering register file
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module wfs_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wfs_pkg::ADDR_W-1:0] paddr,
    input  logic [wfs_pkg::DATA_W-1:0] pwdata,
    output logic [wfs_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output wfs_pkg::cfg_t              cfg
);

    wfs_pkg::cfg_t       cfg_reg;
    wfs_pkg::reg_index_t index;
    logic                wr_en;

    assign index  = wfs_pkg::reg_index_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.side_index      <= 10'd0;
            cfg_reg.angled_index    <= 10'd0;
            cfg_reg.range_limit     <= 16'd65535;
            cfg_reg.steer_gain      <= 16'sd256;
            cfg_reg.target_distance <= 16'd1000;
            cfg_reg.forward_speed   <= 16'd200;
            cfg_reg.beam_cos        <= 16'd23170;
            cfg_reg.beam_sin        <= 16'd23170;
        end
        else if (wr_en)
        begin
            unique case (index)
                wfs_pkg::REG_SIDE_INDEX:    cfg_reg.side_index      <= pwdata[9:0];
                wfs_pkg::REG_ANGLED_INDEX:  cfg_reg.angled_index    <= pwdata[9:0];
                wfs_pkg::REG_RANGE_LIMIT:   cfg_reg.range_limit     <= pwdata[15:0];
                wfs_pkg::REG_STEER_GAIN:    cfg_reg.steer_gain      <= $signed(pwdata[15:0]);
                wfs_pkg::REG_TARGET_DIST:   cfg_reg.target_distance <= pwdata[15:0];
                wfs_pkg::REG_FORWARD_SPEED: cfg_reg.forward_speed   <= pwdata[15:0];
                wfs_pkg::REG_BEAM_COS:      cfg_reg.beam_cos        <= pwdata[15:0];
                wfs_pkg::REG_BEAM_SIN:      cfg_reg.beam_sin        <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            wfs_pkg::REG_SIDE_INDEX:    prdata = {22'd0, cfg_reg.side_index};
            wfs_pkg::REG_ANGLED_INDEX:  prdata = {22'd0, cfg_reg.angled_index};
            wfs_pkg::REG_RANGE_LIMIT:   prdata = {16'd0, cfg_reg.range_limit};
            wfs_pkg::REG_STEER_GAIN:    prdata = {16'd0, cfg_reg.steer_gain};
            wfs_pkg::REG_TARGET_DIST:   prdata = {16'd0, cfg_reg.target_distance};
            wfs_pkg::REG_FORWARD_SPEED: prdata = {16'd0, cfg_reg.forward_speed};
            wfs_pkg::REG_BEAM_COS:      prdata = {16'd0, cfg_reg.beam_cos};
            wfs_pkg::REG_BEAM_SIN:      prdata = {16'd0, cfg_reg.beam_sin};
        endcase
    end

endmodule

// ----- rtl/wfs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall-follow steering controller
// Sequences beam capture, the shared CORDIC, the divider and the output write.
// ----------------------------------------------------------------------------
module wfs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          scan_last,
    input  wfs_pkg::sts_t sts,
    output wfs_pkg::cmd_t cmd,
    output logic          in_stall
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CORDIC_R,
        ST_CORDIC_F,
        ST_PRODUCT,
        ST_DIV_LOAD,
        ST_DIVIDE,
        ST_RATE,
        ST_WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;

    assign in_stall = stall_reg;

    always_comb
    begin
        state_next = state_reg;
        stall_next = stall_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (scan_last)
                    begin
                        cmd.accept_last = 1'b1;
                        stall_next      = 1'b1;
                        state_next      = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = sts.d_zero ? ST_RATE : ST_CORDIC_R;
            end
            ST_CORDIC_R:
            begin
                if (sts.cordic_last)
                begin
                    cmd.cordic_switch = 1'b1;
                    state_next        = ST_CORDIC_F;
                end
                else
                begin
                    cmd.cordic_step = 1'b1;
                end
            end
            ST_CORDIC_F:
            begin
                cmd.cordic_step = 1'b1;
                if (sts.cordic_last)
                begin
                    state_next = ST_PRODUCT;
                end
            end
            ST_PRODUCT:
            begin
                cmd.product = 1'b1;
                state_next  = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_RATE;
                end
            end
            ST_RATE:
            begin
                cmd.rate   = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (sts.out_free)
                begin
                    cmd.write  = 1'b1;
                    stall_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

endmodule

// ----- rtl/wfs_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall-follow steering datapath
// Beam capture, shared vectoring CORDIC, restoring divider, gain and output.
// ----------------------------------------------------------------------------
module wfs_datapath #(
    parameter int SCAN_BEAMS   = 1024,
    parameter int RANGE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wfs_pkg::cfg_t         cfg,
    input  wfs_pkg::cmd_t         cmd,
    output wfs_pkg::sts_t         sts,
    input  logic [RANGE_BITS-1:0] range_sample,
    input  logic                  sample_invalid,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [15:0]    angular_rate,
    output logic [15:0]           linear_speed,
    output logic [15:0]           wall_distance
);

    localparam int CNT_W    = $clog2(SCAN_BEAMS + 1);
    localparam int IDX_W    = (CNT_W > 10) ? CNT_W : 10;
    localparam int SW       = (RANGE_BITS > 16) ? RANGE_BITS : 16;
    localparam int ITER_MAX = (CORDIC_STEPS > wfs_pkg::DIV_STEPS) ?
                              CORDIC_STEPS : wfs_pkg::DIV_STEPS;
    localparam int ITER_W   = $clog2(ITER_MAX);
    localparam int CW       = wfs_pkg::CORDIC_W;
    localparam int PW       = wfs_pkg::PROD_W;

    // Beam capture
    logic [CNT_W-1:0] count_reg;
    logic [15:0]      side_range_reg;
    logic [15:0]      angled_range_reg;
    logic [15:0]      a_op_reg;
    logic [15:0]      b_op_reg;
    logic [SW-1:0]    sample_ext;
    logic [15:0]      range_clip;
    logic             count_ok;
    logic             hit_side;
    logic             hit_angled;
    logic [15:0]      side_next;
    logic [15:0]      angled_next;

    assign sample_ext  = SW'(range_sample);
    assign range_clip  = (sample_invalid || (sample_ext > SW'(cfg.range_limit))) ?
                         cfg.range_limit : sample_ext[15:0];
    assign count_ok    = count_reg < CNT_W'(SCAN_BEAMS);
    assign hit_side    = count_ok && (IDX_W'(count_reg) == IDX_W'(cfg.side_index));
    assign hit_angled  = count_ok && (IDX_W'(count_reg) == IDX_W'(cfg.angled_index));
    assign side_next   = hit_side ? range_clip : side_range_reg;
    assign angled_next = hit_angled ? range_clip : angled_range_reg;

    // Arithmetic state
    logic [ITER_W-1:0]    iter_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] d_reg;
    logic signed [CW-1:0] n_reg;
    logic signed [CW-1:0] xr_reg;
    logic                 zero_reg;
    logic [PW-1:0]        prod_reg;
    logic [PW-1:0]        rem_reg;
    logic [PW-1:0]        dsh_reg;
    logic                 ovf_reg;
    logic [16:0]          quot_reg;
    logic [15:0]          dist_reg;
    logic signed [32:0]   rate_prod_reg;
    logic                 out_valid_reg;
    logic signed [15:0]   rate_out_reg;
    logic [15:0]          speed_out_reg;
    logic [15:0]          dist_out_reg;

    logic [31:0]          ac;
    logic [31:0]          as_prod;
    logic signed [33:0]   n_full;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] x_step;
    logic signed [CW-1:0] y_step;
    logic [CW-1:0]        xf;
    logic [15:0]          dist_val;
    logic signed [16:0]   err;
    logic signed [32:0]   rate_prod;
    logic signed [32:0]   rate_shift;
    logic signed [15:0]   rate_sat;

    assign ac      = 32'(a_op_reg) * 32'(cfg.beam_cos);
    assign as_prod = 32'(a_op_reg) * 32'(cfg.beam_sin);
    assign n_full  = $signed({2'b00, ac}) - $signed({3'b000, b_op_reg, 15'd0});

    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;

    always_comb
    begin
        if (!y_reg[CW-1])
        begin
            x_step = x_reg + dx;
            y_step = y_reg - dy;
        end
        else
        begin
            x_step = x_reg - dx;
            y_step = y_reg + dy;
        end
    end

    assign xf = $unsigned(x_reg);

    assign dist_val = zero_reg ? 16'd0 :
                      ((ovf_reg || quot_reg[16]) ? 16'hFFFF : quot_reg[15:0]);
    assign err       = $signed({1'b0, dist_val}) - $signed({1'b0, cfg.target_distance});
    assign rate_prod = 33'(cfg.steer_gain) * 33'(err);
    assign rate_shift = rate_prod_reg >>> 8;

    always_comb
    begin
        priority if (rate_shift > 33'sd32767)
        begin
            rate_sat = 16'sh7FFF;
        end
        else if (rate_shift < -33'sd32768)
        begin
            rate_sat = -16'sh8000;
        end
        else
        begin
            rate_sat = rate_shift[15:0];
        end
    end

    assign sts.d_zero      = (a_op_reg == 16'd0) || (cfg.beam_sin == 16'd0);
    assign sts.cordic_last = iter_reg == ITER_W'(CORDIC_STEPS - 1);
    assign sts.div_last    = iter_reg == ITER_W'(wfs_pkg::DIV_STEPS - 1);
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign angular_rate  = rate_out_reg;
    assign linear_speed  = speed_out_reg;
    assign wall_distance = dist_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            side_range_reg   <= 16'hFFFF;
            angled_range_reg <= 16'hFFFF;
            iter_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (cmd.accept_last)
                begin
                    count_reg        <= '0;
                    side_range_reg   <= cfg.range_limit;
                    angled_range_reg <= cfg.range_limit;
                end
                else
                begin
                    side_range_reg   <= side_next;
                    angled_range_reg <= angled_next;
                    if (count_ok)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
            end

            priority if (cmd.prep || cmd.cordic_switch || cmd.div_load)
            begin
                iter_reg <= '0;
            end
            else if (cmd.cordic_step || cmd.div_step)
            begin
                iter_reg <= iter_reg + 1'b1;
            end

            priority if (cmd.write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_last)
        begin
            a_op_reg <= angled_next;
            b_op_reg <= side_next;
        end

        priority if (cmd.prep)
        begin
            n_reg    <= CW'(n_full);
            d_reg    <= CW'(as_prod);
            x_reg    <= CW'(as_prod);
            y_reg    <= '0;
            zero_reg <= sts.d_zero;
        end
        else if (cmd.cordic_switch)
        begin
            xr_reg <= x_step;
            x_reg  <= d_reg;
            y_reg  <= n_reg;
        end
        else if (cmd.cordic_step)
        begin
            x_reg <= x_step;
            y_reg <= y_step;
        end

        if (cmd.product)
        begin
            prod_reg <= PW'(b_op_reg) * PW'($unsigned(xr_reg));
        end

        priority if (cmd.div_load)
        begin
            rem_reg  <= prod_reg;
            dsh_reg  <= {xf, 16'd0};
            ovf_reg  <= {1'b0, prod_reg} >= {xf, 17'd0};
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg  <= rem_reg - dsh_reg;
                quot_reg <= {quot_reg[15:0], 1'b1};
            end
            else
            begin
                quot_reg <= {quot_reg[15:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end

        if (cmd.rate)
        begin
            dist_reg      <= dist_val;
            rate_prod_reg <= rate_prod;
        end

        if (cmd.write)
        begin
            rate_out_reg  <= rate_sat;
            speed_out_reg <= cfg.forward_speed;
            dist_out_reg  <= dist_reg;
        end
    end

endmodule

// ----- rtl/wall_follow_steering.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall-follow steering
// Two-beam wall estimate and proportional steering from one lidar scan.
// ----------------------------------------------------------------------------
// Each beat of a scan that is not its last is taken without a stall. The last
// beat of a scan raises in_stall while the shared CORDIC, which runs twice,
// and the 17-step restoring divider do their work (both are skipped when the
// angled range or beam_sin is zero); a waiting result beat can hold in_stall
// high longer, until the new result is written. A finished result waits in
// the output register while the next scan's beats are taken.
module wall_follow_steering #(
    parameter int SCAN_BEAMS   = 1024,
    parameter int RANGE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wfs_pkg::ADDR_W-1:0] paddr,
    input  logic [wfs_pkg::DATA_W-1:0] pwdata,
    output logic [wfs_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [RANGE_BITS-1:0]      range_sample,
    input  logic                       sample_invalid,
    input  logic                       scan_last,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [15:0]         angular_rate,
    output logic [15:0]                linear_speed,
    output logic [15:0]                wall_distance
);

    wfs_pkg::cfg_t cfg;
    wfs_pkg::cmd_t cmd;
    wfs_pkg::sts_t sts;

    wfs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .scan_last (scan_last),
        .sts       (sts),
        .cmd       (cmd),
        .in_stall  (in_stall)
    );

    wfs_datapath #(
        .SCAN_BEAMS   (SCAN_BEAMS),
        .RANGE_BITS   (RANGE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .sts            (sts),
        .range_sample   (range_sample),
        .sample_invalid (sample_invalid),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .angular_rate   (angular_rate),
        .linear_speed   (linear_speed),
        .wall_distance  (wall_distance)
    );

endmodule

// ----- rtl/wfs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall-follow steering checker
// Port-level properties of the steering block, bound to the top level.
// ----------------------------------------------------------------------------
`include "wall_follow_steering_defines.svh"

module wfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        scan_last,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] angular_rate,
    input logic [15:0] linear_speed,
    input logic [15:0] wall_distance
);

    `WFS_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && scan_last, in_stall, "last beat did not stall input")
    `WFS_ASSERT_SAME(a_result_after_busy, $rose(out_valid), $past(in_stall), "result without a finished scan")
    `WFS_ASSERT_SAME(a_release_with_result, $fell(in_stall), out_valid, "input released without a result")
    `WFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(angular_rate) && $stable(linear_speed) && $stable(wall_distance), "stalled result beat changed")

endmodule

bind wall_follow_steering wfs_checker u_wfs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .scan_last     (scan_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .angular_rate  (angular_rate),
    .linear_speed  (linear_speed),
    .wall_distance (wall_distance)
);

// ----- sim/tb_wall_follow_steering.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall-follow steering testbench
// Sends lidar scans into the block in random bursts while the result side
// stalls on a pattern of its own. The registers are rewritten between phases
// while the block is idle. Every steering result is checked field by field
// against a bit-exact CORDIC predictor that the bench keeps for itself.
// ----------------------------------------------------------------------------
module tb_wall_follow_steering;
    import wfs_pkg::*;

    localparam int SCAN_BEAMS   = 1024;
    localparam int CORDIC_STEPS = 16;
    localparam int SETTLE       = 2 * CORDIC_STEPS + 22 + 46;
    localparam int MAX_CYCLES   = 600000;
    localparam int PHASES       = 12;

    typedef struct packed {
        logic [15:0] mm;
        logic        bad;
        logic        last;
    } beat_t;

    typedef struct packed {
        logic signed [15:0] rate;
        logic [15:0]        speed;
        logic [15:0]        wall;
    } steer_t;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_LONG,
        STALL_LIGHT
    } stall_mode_t;

    logic                     clk            = 1'b0;
    logic                     rst_n          = 1'b0;
    logic                     psel           = 1'b0;
    logic                     penable        = 1'b0;
    logic                     pwrite         = 1'b0;
    logic [ADDR_W-1:0]        paddr          = '0;
    logic [DATA_W-1:0]        pwdata         = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     in_valid       = 1'b0;
    logic                     in_stall;
    logic [15:0]              range_sample   = '0;
    logic                     sample_invalid = 1'b0;
    logic                     scan_last      = 1'b0;
    logic                     out_valid;
    logic                     out_stall      = 1'b0;
    logic signed [15:0]       angular_rate;
    logic [15:0]              linear_speed;
    logic [15:0]              wall_distance;

    cfg_t        regs_now;
    int          scan_pos;
    logic [15:0] side_cap;
    logic [15:0] angled_cap;

    beat_t  beats_waiting[$];
    steer_t steer_due[$];

    int beats_queued    = 0;
    int beats_taken     = 0;
    int results_checked = 0;
    int scans_closed    = 0;
    int zero_dist       = 0;
    int settings        = 0;
    int mismatches      = 0;
    int cycle_count     = 0;
    int gap_left        = 0;
    int burst_left      = 0;
    int stall_left      = 0;

    stall_mode_t stall_mode = STALL_NONE;

    wall_follow_steering dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .range_sample   (range_sample),
        .sample_invalid (sample_invalid),
        .scan_last      (scan_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .angular_rate   (angular_rate),
        .linear_speed   (linear_speed),
        .wall_distance  (wall_distance)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic longint cordic_len(longint x_in, longint y_in);
        longint x;
        longint y;
        longint dx;
        longint dy;
        int     i;
        x = x_in;
        y = y_in;
        for (i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
            end
            else
            begin
                x = x - dx;
                y = y + dy;
            end
        end
        return x;
    endfunction

    function automatic void steer_from_beat(logic [15:0] mm, logic bad, logic last);
        logic [15:0] r;
        longint      a;
        longint      b;
        longint      n;
        longint      d;
        longint      wall_mm;
        longint      gain;
        longint      rate;
        steer_t      res;
        r = (bad || mm > regs_now.range_limit) ? regs_now.range_limit : mm;
        if (scan_pos < SCAN_BEAMS)
        begin
            if (scan_pos == int'(regs_now.side_index))
                side_cap = r;
            if (scan_pos == int'(regs_now.angled_index))
                angled_cap = r;
            scan_pos++;
        end
        if (!last)
            return;
        a = longint'(angled_cap);
        b = longint'(side_cap);
        n = a * longint'(regs_now.beam_cos) - b * 32768;
        d = a * longint'(regs_now.beam_sin);
        if (d == 0)
        begin
            wall_mm = 0;
            zero_dist++;
        end
        else
        begin
            wall_mm = (b * cordic_len(d, 0)) / cordic_len(d, n);
            if (wall_mm > 65535)
                wall_mm = 65535;
            if (wall_mm < 0)
                wall_mm = 0;
        end
        gain = longint'($signed(regs_now.steer_gain));
        rate = (gain * (wall_mm - longint'(regs_now.target_distance))) >>> 8;
        if (rate > 32767)
            rate = 32767;
        if (rate < -32768)
            rate = -32768;
        res.rate  = rate[15:0];
        res.speed = regs_now.forward_speed;
        res.wall  = wall_mm[15:0];
        steer_due.push_back(res);
        scans_closed++;
        scan_pos   = 0;
        side_cap   = regs_now.range_limit;
        angled_cap = regs_now.range_limit;
    endfunction

    function automatic void flag(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s", $time, what);
    endfunction

    function automatic int pick_between(int lo, int hi);
        int sel;
        sel = $urandom_range(0, 5);
        if (sel == 0)
            return lo;
        if (sel == 1)
            return hi;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic [15:0] pick_range(logic [15:0] lim);
        case ($urandom_range(0, 9))
            0:       return lim;
            1:       return 16'd0;
            2, 3:    return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, lim));
        endcase
    endfunction

    task automatic reg_write(input reg_index_t idx, input int val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val & 32'h0000_FFFF;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SIDE_INDEX:    regs_now.side_index      = val[9:0];
            REG_ANGLED_INDEX:  regs_now.angled_index    = val[9:0];
            REG_RANGE_LIMIT:   regs_now.range_limit     = val[15:0];
            REG_STEER_GAIN:    regs_now.steer_gain      = val[15:0];
            REG_TARGET_DIST:   regs_now.target_distance = val[15:0];
            REG_FORWARD_SPEED: regs_now.forward_speed   = val[15:0];
            REG_BEAM_COS:      regs_now.beam_cos        = val[15:0];
            REG_BEAM_SIN:      regs_now.beam_sin        = val[15:0];
            default:           ;
        endcase
    endtask

    task automatic apply_setting(input int side, input int angled, input int lim,
                                 input int gain, input int target, input int speed,
                                 input int c, input int s);
        reg_write(REG_SIDE_INDEX, side);
        reg_write(REG_ANGLED_INDEX, angled);
        reg_write(REG_RANGE_LIMIT, lim);
        reg_write(REG_STEER_GAIN, gain);
        reg_write(REG_TARGET_DIST, target);
        reg_write(REG_FORWARD_SPEED, speed);
        reg_write(REG_BEAM_COS, c);
        reg_write(REG_BEAM_SIN, s);
        settings++;
    endtask

    task automatic random_setting();
        int side;
        int angled;
        side   = pick_between(0, 12);
        angled = ($urandom_range(0, 3) == 0) ? side : pick_between(0, 12);
        apply_setting(side, angled, pick_between(0, 65535),
                      $urandom_range(0, 1) ? pick_between(-32768, 32767)
                                           : int'($urandom_range(0, 1024)) - 512,
                      $urandom_range(0, 1) ? pick_between(0, 65535)
                                           : int'($urandom_range(200, 3000)),
                      pick_between(0, 65535), pick_between(0, 32768),
                      pick_between(0, 32768));
    endtask

    task automatic queue_beat(input logic [15:0] mm, input logic bad, input logic last);
        beat_t b;
        b.mm   = mm;
        b.bad  = bad;
        b.last = last;
        beats_waiting.push_back(b);
        beats_queued++;
    endtask

    task automatic queue_scan(input int len);
        int k;
        for (k = 0; k < len; k++)
            queue_beat(pick_range(regs_now.range_limit), $urandom_range(0, 11) == 0,
                       k == len - 1);
    endtask

    task automatic wait_idle();
        while (beats_taken != beats_queued || steer_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Beat driver: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        beat_t next_beat;
        if (in_valid && !in_stall)
        begin
            steer_from_beat(range_sample, sample_invalid, scan_last);
            beats_taken++;
        end
        if (rst_n && !(in_valid && in_stall))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (beats_waiting.size() > 0)
            begin
                next_beat = beats_waiting.pop_front();
                in_valid       <= 1'b1;
                range_sample   <= next_beat.mm;
                sample_invalid <= next_beat.bad;
                scan_last      <= next_beat.last;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                            : $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result stall pattern, switching to a random mode whenever its countdown runs out.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
            STALL_LONG:   out_stall <= (stall_left % 48) < 30;
            default:      out_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Result monitor.
    always @(posedge clk)
    begin
        steer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (steer_due.size() == 0)
                flag($sformatf("unexpected result: rate %0d speed %0d distance %0d",
                               angular_rate, linear_speed, wall_distance));
            else
            begin
                want = steer_due.pop_front();
                results_checked++;
                if (angular_rate !== want.rate)
                    flag($sformatf("result %0d angular_rate: expected %0d, got %0d",
                                   results_checked, want.rate, angular_rate));
                if (linear_speed !== want.speed)
                    flag($sformatf("result %0d linear_speed: expected %0d, got %0d",
                                   results_checked, want.speed, linear_speed));
                if (wall_distance !== want.wall)
                    flag($sformatf("result %0d wall_distance: expected %0d, got %0d",
                                   results_checked, want.wall, wall_distance));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES)
        begin
            $display("wall_follow_steering verification failed");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int phase_beats;
        regs_now.side_index      = 10'd0;
        regs_now.angled_index    = 10'd0;
        regs_now.range_limit     = 16'd65535;
        regs_now.steer_gain      = 16'sd256;
        regs_now.target_distance = 16'd1000;
        regs_now.forward_speed   = 16'd200;
        regs_now.beam_cos        = 16'd23170;
        regs_now.beam_sin        = 16'd23170;
        scan_pos   = 0;
        side_cap   = 16'hFFFF;
        angled_cap = 16'hFFFF;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Settings after reset: both indices on beam zero, so one beam feeds both.
        queue_beat(16'd0, 1'b0, 1'b1);
        queue_beat(16'd4321, 1'b1, 1'b1);
        queue_beat(16'd65535, 1'b0, 1'b0);
        queue_beat(16'd12345, 1'b0, 1'b1);
        wait_idle();

        // Substitution of out-of-range and invalid samples, capture on the last
        // beat, an unreached index, and a zero angled range.
        apply_setting(0, 3, 5000, -32768, 65535, 65535, 32768, 32768);
        queue_beat(16'd1000, 1'b0, 1'b0);
        queue_beat(16'd65535, 1'b0, 1'b0);
        queue_beat(16'd2500, 1'b1, 1'b0);
        queue_beat(16'd1414, 1'b0, 1'b1);
        queue_beat(16'd900, 1'b0, 1'b1);
        queue_beat(16'd800, 1'b0, 1'b0);
        queue_beat(16'd5000, 1'b0, 1'b0);
        queue_beat(16'd0, 1'b0, 1'b0);
        queue_beat(16'd0, 1'b0, 1'b1);
        queue_beat(16'd5000, 1'b0, 1'b0);
        queue_beat(16'd1, 1'b0, 1'b0);
        queue_beat(16'd4999, 1'b0, 1'b0);
        queue_beat(16'd5001, 1'b0, 1'b0);
        queue_beat(16'd3, 1'b0, 1'b1);
        wait_idle();

        apply_setting(2, 2, 0, 0, 0, 0, 0, 0);
        queue_beat(16'd65535, 1'b0, 1'b0);
        queue_beat(16'd65535, 1'b1, 1'b0);
        queue_beat(16'd32768, 1'b0, 1'b1);
        wait_idle();

        // Highest indices and a scan that runs past the beam counter's end.
        apply_setting(1023, 1020, 40000, 32767, 0, 1, 30000, 12540);
        queue_scan(1030);
        queue_scan(4);
        queue_scan(2);
        wait_idle();

        for (phase = 0; phase < PHASES; phase++)
        begin
            random_setting();
            phase_beats = 0;
            while (phase_beats < 60)
            begin
                int len;
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(1, 16);
                queue_scan(len);
                phase_beats += len;
            end
            wait_idle();
        end

        $display("Sent %0d beats closing %0d scans under %0d register settings.",
                 beats_taken, scans_closed, settings);
        $display("Checked %0d steering results, %0d of them with a zero denominator.",
                 results_checked, zero_dist);
        if (mismatches == 0 && steer_due.size() == 0)
            $display("wall_follow_steering verification clean");
        else
            $display("wall_follow_steering verification failed");
        $finish;
    end

endmodule
